@@ hdl/tsd_pkg.sv @@
// Shared constants for the torus squared-distance block.
// Field widths, register map codes and register reset values.
// No dependencies.
package tsd_pkg;

   // item field widths
   localparam int INDEX_W = 30;
   localparam int DIST_W  = 20;

   // configuration registers
   localparam int SIDE_REG_W = 11;
   localparam int DIM_REG_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic REG_SIDE = 1'b0;
   localparam logic REG_DIMS = 1'b1;

   localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 11'd64;
   localparam logic [DIM_REG_W-1:0]  DIMS_RESET = 2'd3;
   localparam logic [DIM_REG_W-1:0]  DIMS_FLAT  = 2'd2;

   // largest supported lattice side
   localparam int MAX_SIDE_DEF = 1024;

   // restoring-division steps per pipeline stage
   localparam int DIV_STEPS = 4;

endpackage

@@ hdl/tsd_div.sv @@
// Pipelined restoring divider for two lanes sharing one divisor.
// STEP quotient bits per stage; carries a sideband word alongside.
// Depends on nothing outside this file.
module tsd_div #(
   parameter int QW   = 20,
   parameter int SW   = 11,
   parameter int STEP = 4,
   parameter int DW   = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [SW-1:0]          side,
   input  logic [1:0][SW-1:0]     in_hi,
   input  logic [1:0][QW-1:0]     in_lo,
   input  logic [DW-1:0]          in_data,
   output logic                   out_valid,
   output logic [1:0][QW-1:0]     out_quot,
   output logic [1:0][SW-1:0]     out_rem,
   output logic [DW-1:0]          out_data
);

   localparam int NST = (QW + STEP - 1) / STEP;

   logic                  vld_ff  [NST];
   logic [1:0][SW-1:0]    rem_ff  [NST];
   logic [1:0][QW-1:0]    num_ff  [NST];
   logic [DW-1:0]         data_ff [NST];

   logic [1:0][SW-1:0]    rem_in  [NST];
   logic [1:0][QW-1:0]    num_in  [NST];

   genvar k;
   generate
      for (k = 0; k < NST; k++) begin : g_stage
         logic               vld_s;
         logic [1:0][SW-1:0] rem_s;
         logic [1:0][QW-1:0] num_s;
         logic [DW-1:0]      data_s;

         if (k == 0) begin : g_first
            assign vld_s  = in_valid;
            assign rem_s  = in_hi;
            assign num_s  = in_lo;
            assign data_s = in_data;
         end else begin : g_next
            assign vld_s  = vld_ff[k-1];
            assign rem_s  = rem_ff[k-1];
            assign num_s  = num_ff[k-1];
            assign data_s = data_ff[k-1];
         end

         // shift in one dividend bit per step, subtract when it fits
         always_comb begin
            logic [SW:0] wide;
            logic        fit;
            rem_in[k] = rem_s;
            num_in[k] = num_s;
            for (int ln = 0; ln < 2; ln++) begin
               for (int t = 0; t < STEP; t++) begin
                  if (k * STEP + t < QW) begin
                     wide = {rem_in[k][ln], num_in[k][ln][QW-1]};
                     fit  = (wide >= {1'b0, side});
                     if (fit) begin
                        rem_in[k][ln] = SW'(wide - {1'b0, side});
                     end else begin
                        rem_in[k][ln] = SW'(wide);
                     end
                     num_in[k][ln] = {num_in[k][ln][QW-2:0], fit};
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= vld_s;
            end
            rem_ff[k]  <= rem_in[k];
            num_ff[k]  <= num_in[k];
            data_ff[k] <= data_s;
         end
      end
   endgenerate

   assign out_valid = vld_ff[NST-1];
   assign out_quot  = num_ff[NST-1];
   assign out_rem   = rem_ff[NST-1];
   assign out_data  = data_ff[NST-1];

   // valid bit is always known out of reset
   a_valid_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(out_valid))
      else $error("tsd_div: unknown valid bit");

   // a valid item leaves with known quotient and remainder
   a_out_known: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !$isunknown({out_quot, out_rem}))
      else $error("tsd_div: unknown quotient or remainder");

   // first stage valid is the registered input valid
   a_first_stage: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] == $past(in_valid))
      else $error("tsd_div: first stage valid lost or repeated");

endmodule

@@ hdl/torus_squared_distance.sv @@
// Top level: minimum-image squared distance on a periodic 2D/3D lattice.
// Depends on tsd_pkg and tsd_div.
//
// Usage
//   Input items: raise start with req_first_node/req_second_node; busy is
//   always low, so an item is taken at every edge where start is high.
//   Results: rsp_strobe is high for one cycle with rsp_squared_distance and
//   rsp_out_of_range. The receiver cannot stall; results are never held.
//   Throughput: one item per cycle. The pipeline is an input register,
//   the two restoring dividers (index / side, then quotient / side),
//   four quotient bits per stage, and the fold, square and sum stages.
//   Configuration: APB writes to side_length (addr 0) and dimensions
//   (addr 4) while no item is in flight; derived lattice size settles
//   via eff_side_ff, plane_ff, count_ff, ahead of any item's range check.
//   Reset: clears the pipeline valid bits and loads side 64, cubic lattice.
module torus_squared_distance #(
   parameter int MAX_SIDE = tsd_pkg::MAX_SIDE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input item
   input  logic                            start,
   output logic                            busy,
   input  logic [tsd_pkg::INDEX_W-1:0]     req_first_node,
   input  logic [tsd_pkg::INDEX_W-1:0]     req_second_node,
   // result item
   output logic                            rsp_strobe,
   output logic [tsd_pkg::DIST_W-1:0]      rsp_squared_distance,
   output logic                            rsp_out_of_range,
   // configuration
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tsd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tsd_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tsd_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   localparam int IW   = tsd_pkg::INDEX_W;
   localparam int CW   = $clog2(MAX_SIDE);
   localparam int SW   = CW + 1;
   localparam int QW   = 2 * CW;
   localparam int CMPW = (3 * SW > IW) ? 3 * SW : IW;
   localparam int SQW  = 2 * CW;
   localparam int SUMW = (SQW + 2 > tsd_pkg::DIST_W) ? SQW + 2 : tsd_pkg::DIST_W;
   localparam int STEP = tsd_pkg::DIV_STEPS;
   localparam int L1   = (QW + STEP - 1) / STEP;
   localparam int L2   = (CW + STEP - 1) / STEP;
   localparam int LAT  = 5 + L1 + L2;
   localparam int MAXD = 3 * (MAX_SIDE / 2) * (MAX_SIDE / 2);

   // minimum-image fold of one axis
   function automatic logic [CW-1:0] axis_fold(input logic [SW-1:0] a,
                                               input logic [SW-1:0] b,
                                               input logic [SW-1:0] s);
      logic [SW-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      if (d > (s >> 1)) begin
         d = s - d;
      end
      return CW'(d);
   endfunction

   // ---------------- configuration registers ----------------
   logic [tsd_pkg::SIDE_REG_W-1:0] side_ff;
   logic [tsd_pkg::DIM_REG_W-1:0]  dims_ff;
   logic                           csr_wr;
   logic                           csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= tsd_pkg::SIDE_RESET;
         dims_ff <= tsd_pkg::DIMS_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            tsd_pkg::REG_SIDE: side_ff <= pwdata[tsd_pkg::SIDE_REG_W-1:0];
            tsd_pkg::REG_DIMS: dims_ff <= pwdata[tsd_pkg::DIM_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         tsd_pkg::REG_SIDE: prdata = tsd_pkg::CSR_DATA_W'(side_ff);
         tsd_pkg::REG_DIMS: prdata = tsd_pkg::CSR_DATA_W'(dims_ff);
         default:           prdata = '0;
      endcase
   end

   // clamped side and lattice node count, settled after a write
   logic [SW-1:0]     eff_side_ff, eff_side_in;
   logic [2*SW-1:0]   plane_ff;
   logic [CMPW-1:0]   count_ff, count_in;
   logic [3*SW-1:0]   cube;

   always_comb begin
      if (side_ff < tsd_pkg::SIDE_REG_W'(2)) begin
         eff_side_in = SW'(2);
      end else if (32'(side_ff) > 32'(MAX_SIDE)) begin
         eff_side_in = SW'(MAX_SIDE);
      end else begin
         eff_side_in = SW'(side_ff);
      end
   end

   assign cube     = (3 * SW)'(plane_ff) * (3 * SW)'(eff_side_ff);
   assign count_in = (dims_ff == tsd_pkg::DIMS_FLAT) ? CMPW'(plane_ff) : CMPW'(cube);

   always_ff @(posedge clock) begin
      eff_side_ff <= eff_side_in;
      plane_ff    <= (2 * SW)'(eff_side_ff) * (2 * SW)'(eff_side_ff);
      count_ff    <= count_in;
   end

   // ---------------- stage A: take the item ----------------
   logic          a_vld_ff;
   logic [IW-1:0] a_first_ff, a_second_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy;
      end
      a_first_ff  <= req_first_node;
      a_second_ff <= req_second_node;
   end

   // ---------------- divider 1: index / side ----------------
   logic [1:0][SW-1:0]  d1_hi;
   logic [1:0][QW-1:0]  d1_lo;
   logic                d1_vld;
   logic [1:0][QW-1:0]  d1_quot;
   logic [1:0][SW-1:0]  d1_rem;
   logic [2*IW-1:0]     d1_data;

   assign d1_hi[0] = SW'(a_first_ff[3*CW-1:QW]);
   assign d1_hi[1] = SW'(a_second_ff[3*CW-1:QW]);
   assign d1_lo[0] = a_first_ff[QW-1:0];
   assign d1_lo[1] = a_second_ff[QW-1:0];

   tsd_div #(.QW(QW), .SW(SW), .STEP(STEP), .DW(2 * IW)) u_div_index (
      .clock    (clock),
      .reset    (reset),
      .in_valid (a_vld_ff),
      .side     (eff_side_ff),
      .in_hi    (d1_hi),
      .in_lo    (d1_lo),
      .in_data  ({a_first_ff, a_second_ff}),
      .out_valid(d1_vld),
      .out_quot (d1_quot),
      .out_rem  (d1_rem),
      .out_data (d1_data)
   );

   // ---------------- stage C: range check, x axis ----------------
   logic                c_vld_ff;
   logic [1:0][QW-1:0]  c_quot_ff;
   logic                c_oor_ff, c_oor_in;
   logic [CW-1:0]       c_dx_ff;

   assign c_oor_in = (CMPW'(d1_data[2*IW-1:IW]) >= count_ff) ||
                     (CMPW'(d1_data[IW-1:0]) >= count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= d1_vld;
      end
      c_quot_ff <= d1_quot;
      c_oor_ff  <= c_oor_in;
      c_dx_ff   <= axis_fold(d1_rem[0], d1_rem[1], eff_side_ff);
   end

   // ---------------- divider 2: plane index / side ----------------
   // in 2D the quotient is below side, so z comes out zero
   logic [1:0][SW-1:0]  d2_hi;
   logic [1:0][CW-1:0]  d2_lo;
   logic                d2_vld;
   logic [1:0][CW-1:0]  d2_quot;
   logic [1:0][SW-1:0]  d2_rem;
   logic [CW:0]         d2_data;

   assign d2_hi[0] = SW'(c_quot_ff[0][QW-1:CW]);
   assign d2_hi[1] = SW'(c_quot_ff[1][QW-1:CW]);
   assign d2_lo[0] = c_quot_ff[0][CW-1:0];
   assign d2_lo[1] = c_quot_ff[1][CW-1:0];

   tsd_div #(.QW(CW), .SW(SW), .STEP(STEP), .DW(CW + 1)) u_div_plane (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c_vld_ff),
      .side     (eff_side_ff),
      .in_hi    (d2_hi),
      .in_lo    (d2_lo),
      .in_data  ({c_oor_ff, c_dx_ff}),
      .out_valid(d2_vld),
      .out_quot (d2_quot),
      .out_rem  (d2_rem),
      .out_data (d2_data)
   );

   // ---------------- stage E: y and z axes ----------------
   logic          e_vld_ff, e_oor_ff;
   logic [CW-1:0] e_dx_ff, e_dy_ff, e_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d2_vld;
      end
      e_oor_ff <= d2_data[CW];
      e_dx_ff  <= d2_data[CW-1:0];
      e_dy_ff  <= axis_fold(d2_rem[0], d2_rem[1], eff_side_ff);
      e_dz_ff  <= axis_fold(SW'(d2_quot[0]), SW'(d2_quot[1]), eff_side_ff);
   end

   // ---------------- stage F: squares ----------------
   logic           f_vld_ff, f_oor_ff;
   logic [SQW-1:0] f_sx_ff, f_sy_ff, f_sz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= e_vld_ff;
      end
      f_oor_ff <= e_oor_ff;
      f_sx_ff  <= SQW'(e_dx_ff) * SQW'(e_dx_ff);
      f_sy_ff  <= SQW'(e_dy_ff) * SQW'(e_dy_ff);
      f_sz_ff  <= SQW'(e_dz_ff) * SQW'(e_dz_ff);
   end

   // ---------------- stage G: sum and result register ----------------
   logic                       g_vld_ff;
   logic                       g_oor_ff;
   logic [tsd_pkg::DIST_W-1:0] g_dist_ff, g_dist_in;
   logic [SUMW-1:0]            sum;

   assign sum       = SUMW'(f_sx_ff) + SUMW'(f_sy_ff) + SUMW'(f_sz_ff);
   assign g_dist_in = f_oor_ff ? '0 : sum[tsd_pkg::DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= f_vld_ff;
      end
      g_oor_ff  <= f_oor_ff;
      g_dist_ff <= g_dist_in;
   end

   assign rsp_strobe           = g_vld_ff;
   assign rsp_out_of_range     = g_oor_ff;
   assign rsp_squared_distance = g_dist_ff;

   // ---------------- checks ----------------
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LAT))
      else $error("result without an item taken %0d cycles before", LAT);

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_of_range) |-> (rsp_squared_distance == '0))
      else $error("out-of-range item with nonzero distance");

   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_out_of_range) |->
         (32'(rsp_squared_distance) <= 32'(MAXD)))
      else $error("distance above largest minimum-image value");

endmodule

@@ tb/sv/torus_squared_distance_tb.sv @@
// Testbench for torus_squared_distance: directed table plus random node pairs,
// checked against typed-in answers or an in-bench minimum-image distance predictor.
// Depends on tsd_pkg and the torus_squared_distance RTL.
`timescale 1ns / 1ps

module torus_squared_distance_tb;

   localparam int MAX_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 30;
   localparam logic [tsd_pkg::CSR_ADDR_W-1:0] ADDR_SIDE =
      tsd_pkg::CSR_ADDR_W'(4 * tsd_pkg::REG_SIDE);
   localparam logic [tsd_pkg::CSR_ADDR_W-1:0] ADDR_DIMS =
      tsd_pkg::CSR_ADDR_W'(4 * tsd_pkg::REG_DIMS);

   typedef struct packed {
      logic [tsd_pkg::DIST_W-1:0] sqd;
      logic                       oor;
   } dist_rsp_type;

   // directed row: node pair, optional typed-in answer
   typedef struct {
      logic [tsd_pkg::INDEX_W-1:0] a;
      logic [tsd_pkg::INDEX_W-1:0] b;
      bit                          fixed;
      dist_rsp_type                ans;
   } pair_row_type;

   logic clock, reset, start, busy;
   logic [tsd_pkg::INDEX_W-1:0] req_first_node, req_second_node;
   logic rsp_strobe, rsp_out_of_range;
   logic [tsd_pkg::DIST_W-1:0] rsp_squared_distance;
   logic psel, penable, pwrite, pready;
   logic [tsd_pkg::CSR_ADDR_W-1:0] paddr;
   logic [tsd_pkg::CSR_DATA_W-1:0] pwdata, prdata;

   // predictor copy of the registers
   logic [tsd_pkg::SIDE_REG_W-1:0] lat_side;
   logic [tsd_pkg::DIM_REG_W-1:0]  lat_dims;

   dist_rsp_type pending_dist[$];
   int mismatches;
   int cycle_count;

   torus_squared_distance DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_node(req_first_node), .req_second_node(req_second_node),
      .rsp_strobe(rsp_strobe), .rsp_squared_distance(rsp_squared_distance),
      .rsp_out_of_range(rsp_out_of_range),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned fold_sq(longint unsigned p, longint unsigned q,
                                               longint unsigned s);
      longint unsigned d;
      d = (p > q) ? p - q : q - p;
      if (d > s / 2) d = s - d;
      return d * d;
   endfunction

   function automatic dist_rsp_type torus_dist(logic [tsd_pkg::INDEX_W-1:0] a,
                                               logic [tsd_pkg::INDEX_W-1:0] b);
      longint unsigned s, plane, nodes, x, y, sum;
      dist_rsp_type r;
      bit flat;
      s = lat_side;
      if (s < 2) s = 2;
      if (s > tsd_pkg::MAX_SIDE_DEF) s = tsd_pkg::MAX_SIDE_DEF;
      flat = (lat_dims == tsd_pkg::DIMS_FLAT);
      plane = s * s;
      nodes = flat ? plane : plane * s;
      x = a;
      y = b;
      r.sqd = '0;
      r.oor = 1'b0;
      if (x >= nodes || y >= nodes) begin
         r.oor = 1'b1;
         return r;
      end
      sum = fold_sq(x % s, y % s, s);
      if (flat) begin
         sum += fold_sq(x / s, y / s, s);
      end else begin
         sum += fold_sq((x % plane) / s, (y % plane) / s, s);
         sum += fold_sq(x / plane, y / plane, s);
      end
      r.sqd = sum[tsd_pkg::DIST_W-1:0];
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      dist_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_dist.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result dist=%0d oor=%0b",
                        rsp_squared_distance, rsp_out_of_range);
         end else begin
            want = pending_dist.pop_front();
            if (want.sqd !== rsp_squared_distance || want.oor !== rsp_out_of_range) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected dist=%0d oor=%0b, got dist=%0d oor=%0b",
                           want.sqd, want.oor, rsp_squared_distance, rsp_out_of_range);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLES) begin
         $display("torus_squared_distance_tb: done, errors");
         $finish;
      end
   end

   task automatic csr_write(logic [tsd_pkg::CSR_ADDR_W-1:0] addr,
                            logic [tsd_pkg::CSR_DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_SIDE) lat_side = data[tsd_pkg::SIDE_REG_W-1:0];
      else if (addr == ADDR_DIMS) lat_dims = data[tsd_pkg::DIM_REG_W-1:0];
      // leave the bus idle before the next transfer
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_dist.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_lattice(int unsigned side, int unsigned dims);
      wait_drained();
      csr_write(ADDR_SIDE, side);
      csr_write(ADDR_DIMS, dims);
      repeat (4) @(posedge clock);
   endtask

   // send one item; start stays high across back-to-back items
   task automatic send_pair(logic [tsd_pkg::INDEX_W-1:0] a, logic [tsd_pkg::INDEX_W-1:0] b,
                            bit fixed, dist_rsp_type ans);
      int gap;
      start <= 1'b1;
      req_first_node <= a;
      req_second_node <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_dist.push_back(fixed ? ans : torus_dist(a, b));
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [tsd_pkg::INDEX_W-1:0] node_in(int unsigned side,
                                                          int unsigned dims);
      longint unsigned s, n;
      s = (side < 2) ? 2 : (side > tsd_pkg::MAX_SIDE_DEF) ? tsd_pkg::MAX_SIDE_DEF : side;
      n = (dims == tsd_pkg::DIMS_FLAT) ? s * s : s * s * s;
      case ($urandom_range(0, 19))
         0: return tsd_pkg::INDEX_W'($urandom());
         1: return tsd_pkg::INDEX_W'(n);
         2: return tsd_pkg::INDEX_W'(n - 1);
         3: return '0;
         default: return tsd_pkg::INDEX_W'({$urandom(), $urandom()} % n);
      endcase
   endfunction

   initial begin
      pair_row_type rows[$];
      dist_rsp_type zero_rsp, oor_rsp;
      int unsigned sides[] = '{2, 3, 64, 1024, 0, 1, 2047, 5, 17, 1000, 31, 256};
      int unsigned side, dims;
      logic [tsd_pkg::INDEX_W-1:0] na, nb;
      mismatches = 0;
      cycle_count = 0;
      lat_side = tsd_pkg::SIDE_RESET;
      lat_dims = tsd_pkg::DIMS_RESET;
      reset <= 1'b1;
      start <= 1'b0;
      req_first_node <= '0;
      req_second_node <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      zero_rsp = '{sqd: '0, oor: 1'b0};
      oor_rsp = '{sqd: '0, oor: 1'b1};
      // directed: reset lattice 64^3 = 262144 nodes
      rows.push_back('{'0, '0, 1, zero_rsp});
      rows.push_back('{30'd262143, 30'd262143, 1, zero_rsp});
      rows.push_back('{30'd262144, 30'd0, 1, oor_rsp});
      rows.push_back('{30'd0, 30'd262144, 1, oor_rsp});
      rows.push_back('{30'h3FFFFFFF, 30'h3FFFFFFF, 1, oor_rsp});
      rows.push_back('{30'd0, 30'd32, 1, '{20'd1024, 1'b0}});
      rows.push_back('{30'd0, 30'd33, 1, '{20'd961, 1'b0}});
      rows.push_back('{30'd0, 30'd262143, 1, '{20'd3, 1'b0}});
      rows.push_back('{30'd0, 30'h2AAAA, 0, zero_rsp});
      rows.push_back('{30'h15555, 30'h2AAAA, 0, zero_rsp});
      foreach (rows[i]) send_pair(rows[i].a, rows[i].b, rows[i].fixed, rows[i].ans);
      start <= 1'b0;

      // largest cubic lattice: worst-case distance 3*512^2
      set_lattice(1024, 3);
      send_pair(30'd0, 30'd512 + 30'd512 * 1024 + 30'd512 * 1048576, 1,
                '{20'd786432, 1'b0});
      send_pair(30'h3FFFFFFF, 30'd0, 1, '{20'd3, 1'b0});
      // side below two clamps to 2, dimension code 0 means cubic
      start <= 1'b0;
      set_lattice(1, 0);
      send_pair(30'd7, 30'd0, 1, '{20'd3, 1'b0});
      send_pair(30'd8, 30'd0, 1, oor_rsp);
      // side above maximum clamps, square lattice
      start <= 1'b0;
      set_lattice(2047, 2);
      send_pair(30'd1048575, 30'd0, 1, '{20'd2, 1'b0});
      send_pair(30'd1048576, 30'd0, 1, oor_rsp);
      start <= 1'b0;

      // random phases over several lattice settings
      foreach (sides[k]) begin
         side = sides[k];
         dims = $urandom_range(0, 3);
         set_lattice(side, dims);
         repeat (125) begin
            na = node_in(side, dims);
            nb = node_in(side, dims);
            if ($urandom_range(0, 30) == 0) begin
               na = tsd_pkg::INDEX_W'($urandom());
               nb = ~na;
            end
            send_pair(na, nb, 0, zero_rsp);
         end
         start <= 1'b0;
         if (k == 3) begin
            while (pending_dist.size() != 0) @(posedge clock);
         end
      end

      wait_drained();
      if (mismatches == 0 && pending_dist.size() == 0)
         $display("torus_squared_distance_tb: done, clean");
      else
         $display("torus_squared_distance_tb: done, errors");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/tsd_pkg.sv
hdl/tsd_div.sv
hdl/torus_squared_distance.sv
tb/sv/torus_squared_distance_tb.sv
